@@ src/pil_pkg.sv @@
// shared types and constants for the positional list
package pil_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int GROUP_SIZE     = 16;
  localparam int POS_W          = 8;
  localparam int CAP_W          = 5;
  localparam int VAL_W          = 32;
  localparam int CNT_OUT_W      = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_GET    = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             load;  // capture read tap
    logic             rd;    // tap takes the entry at pos
    logic             ins;   // shift up from pos, write word at pos
    logic             del;   // shift down onto pos
    logic [POS_W-1:0] pos;
  } pil_cmd_t;

endpackage

@@ src/pil_cell.sv @@
// one list entry with its neighbor shift paths and read tap
module pil_cell
  import pil_pkg::*;
#(
  parameter int IDX = 0,
  parameter int W   = 32
) (
  input  logic         clk,
  input  pil_cmd_t     cmd,
  input  logic [W-1:0] word,
  input  logic [W-1:0] left_data,
  input  logic [W-1:0] right_data,
  output logic [W-1:0] data_o,
  output logic [W-1:0] tap_o
);

  localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;
  logic [W-1:0] tap_r;

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (IDX_P > cmd.pos) begin
        data_nxt = left_data;
      end else if (IDX_P == cmd.pos) begin
        data_nxt = word;
      end
    end else if (cmd.del) begin
      if (IDX_P >= cmd.pos) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (cmd.load) begin
      tap_r <= (cmd.rd && IDX_P == cmd.pos) ? data_r : '0;
    end
  end

  assign data_o = data_r;
  assign tap_o  = tap_r;

endmodule

@@ src/pil_reduce.sv @@
// registered first level of the read-tap or tree, one word per group of cells
module pil_reduce
  import pil_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int W     = 32,
  parameter int NG    = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [DEPTH-1:0][W-1:0]  taps,
  output logic [NG-1:0][W-1:0]     groups_o
);

  logic [NG-1:0][W-1:0] groups_r;
  logic [NG-1:0][W-1:0] groups_nxt;

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      groups_nxt[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < DEPTH) begin
          groups_nxt[g] = groups_nxt[g] | taps[g * GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      groups_r <= groups_nxt;
    end
  end

  assign groups_o = groups_r;

endmodule

@@ src/positional_list_insert_delete.sv @@
// top level: positional list as a chain of entry cells with a pipelined read path
//
// request channel in_*: valid/ready, one beat per request (insert, get, delete,
//   clear). the list contents and length change at the edge that takes the beat,
//   so the next request sees them at once
// result channel out_*: valid/ready, exactly one result beat per request, in order
// throughput: one request per cycle unless the receiver stalls on out_ready; the read path
//   is three register stages (cell read tap, group or, output register), each of which
//   advances when the stage after it is empty or moving on
// stall: while the receiver holds out_ready low the stages fill up; in_ready
//   drops once all three hold a result and rises again in the cycle the output beat is taken
// config: APB-style register at byte 0, list_capacity, reset 16; write only
//   while no request is in flight
// reset: length 0, capacity 16, pipeline empty; entry contents are undefined
//   until inserted and are never read before that
module positional_list_insert_delete
  import pil_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [POS_W-1:0]     in_position,
  input  logic [VAL_W-1:0]     in_write_value,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_result_status,
  output logic [VAL_W-1:0]     out_read_value,
  output logic [CNT_OUT_W-1:0] out_element_count,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // stored word is never wider than the 32-bit payload
  localparam int SW    = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int NG    = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  // ---------------- config register ----------------
  logic [CAP_W-1:0] cap_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(16);
    end else if (cfg_wr) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // ---------------- pipeline handshake ----------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_go, s2_go, s1_go, in_fire;

  assign out_go   = !out_v_r || out_ready;
  assign s2_go    = s2_v_r && out_go;
  assign s1_go    = s1_v_r && (!s2_v_r || s2_go);
  assign in_ready = !s1_v_r || !s2_v_r || out_go;
  assign in_fire  = in_valid && in_ready;

  // ---------------- request decode ----------------
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  req_t             req;
  logic             full;
  logic             bad_pos;
  status_t          status;
  pil_cmd_t         cmd;

  assign req     = req_t'(in_req_type);
  // capacity above DEPTH is limited by the depth check
  assign full    = (32'(count_r) >= 32'(cap_r)) || (32'(count_r) >= 32'(DEPTH));
  assign bad_pos = 32'(in_position) >= 32'(count_r);

  always_comb begin
    count_nxt = count_r;
    status    = ST_OK;
    cmd.load  = in_fire;
    cmd.rd    = 1'b0;
    cmd.ins   = 1'b0;
    cmd.del   = 1'b0;
    cmd.pos   = in_position;
    case (req)
      REQ_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.ins   = in_fire;
          count_nxt = count_r + CNT_W'(1);
          // past the end appends
          if (bad_pos) begin
            cmd.pos = POS_W'(count_r);
          end
        end
      end
      REQ_GET: begin
        if (bad_pos) begin
          status = ST_BAD_POS;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (bad_pos) begin
          status = ST_BAD_POS;
        end else begin
          cmd.rd    = 1'b1;
          cmd.del   = in_fire;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_fire) begin
      count_r <= count_nxt;
    end
  end

  // ---------------- chain of entry cells ----------------
  logic [DEPTH-1:0][SW-1:0] cell_data;
  logic [DEPTH-1:0][SW-1:0] cell_tap;
  logic [SW-1:0]            word;

  assign word = in_write_value[SW-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SW-1:0] left_d;
    logic [SW-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = cell_data[i];
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    pil_cell #(
      .IDX (i),
      .W   (SW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .word       (word),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[i]),
      .tap_o      (cell_tap[i])
    );
  end

  // ---------------- read path and result metadata ----------------
  logic [NG-1:0][SW-1:0] groups;
  logic [SW-1:0]         gathered;
  status_t               s1_st_r, s2_st_r, out_st_r;
  logic [CNT_W-1:0]      s1_cnt_r, s2_cnt_r, out_cnt_r;
  logic [SW-1:0]         out_val_r;

  pil_reduce #(
    .DEPTH (DEPTH),
    .W     (SW),
    .NG    (NG)
  ) u_reduce (
    .clk      (clk),
    .en       (s1_go),
    .taps     (cell_tap),
    .groups_o (groups)
  );

  always_comb begin
    gathered = '0;
    for (int g = 0; g < NG; g++) begin
      gathered = gathered | groups[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        s2_v_r <= 1'b1;
      end else if (s2_go) begin
        s2_v_r <= 1'b0;
      end
      if (s2_go) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_st_r  <= status;
      s1_cnt_r <= count_nxt;
    end
    if (s1_go) begin
      s2_st_r  <= s1_st_r;
      s2_cnt_r <= s1_cnt_r;
    end
    if (s2_go) begin
      out_st_r  <= s2_st_r;
      out_cnt_r <= s2_cnt_r;
      out_val_r <= gathered;
    end
  end

  assign out_valid         = out_v_r;
  assign out_result_status = out_st_r;
  assign out_read_value    = VAL_W'(out_val_r);
  assign out_element_count = CNT_OUT_W'(out_cnt_r);

`ifndef SYNTHESIS
  // length never exceeds the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DEPTH))
    else $error("list length above depth");

  // a rejected insert leaves the length alone
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_INSERT && full) |=> $stable(count_r))
    else $error("rejected insert changed the length");

  // clear empties the list
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req == REQ_CLEAR) |=> (count_r == '0))
    else $error("clear left entries");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the positional list: directed, capacity and random request traffic
module testbench;
  import pil_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int LIST_LATENCY = 3;        // request beat to result beat
  localparam int CYCLE_LIMIT  = 400000;   // far above the slowest legal run
  localparam logic [2:0] CAP_REG_ADDR = 3'd0;

  // one expected result beat
  typedef struct {
    status_t     status;
    logic [31:0] value;
    logic [4:0]  count;
  } list_result_t;

  logic clk;
  logic rst_n;

  // request channel
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_req_type;
  logic [POS_W-1:0]     in_position;
  logic [VAL_W-1:0]     in_write_value;

  // result channel
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_result_status;
  logic [VAL_W-1:0]     out_read_value;
  logic [CNT_OUT_W-1:0] out_element_count;

  // register port
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the list, its length and the capacity register
  logic [31:0]  list_words [LIST_DEPTH];
  int           list_len;
  int           list_cap_reg;
  list_result_t pending_list_results [$];

  int fail_count;
  int cycle_count;
  bit steady_traffic;   // when set, neither side inserts gaps

  positional_list_insert_delete DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_position       (in_position),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_status (out_result_status),
    .out_read_value    (out_read_value),
    .out_element_count (out_element_count),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_traffic) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // list behavior for one accepted request; updates the shadow state
  function automatic list_result_t predict_list_request(req_t kind, logic [7:0] pos,
                                                        logic [31:0] word);
    list_result_t r;
    int eff_cap;
    int p;
    // capacity above the store size means the whole store
    eff_cap  = (list_cap_reg > LIST_DEPTH) ? LIST_DEPTH : list_cap_reg;
    r.status = ST_OK;
    r.value  = '0;
    p        = int'(pos);
    case (kind)
      REQ_INSERT: begin
        // full also covers capacity zero and capacity lowered below the length
        if (list_len >= eff_cap) begin
          r.status = ST_FULL;
        end else begin
          // a position past the end appends
          if (p > list_len) p = list_len;
          for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = word;
          list_len++;
        end
      end
      REQ_GET: begin
        if (p >= list_len) r.status = ST_BAD_POS;
        else r.value = list_words[p];
      end
      REQ_DELETE: begin
        if (p >= list_len) begin
          r.status = ST_BAD_POS;
        end else begin
          r.value = list_words[p];
          for (int i = p + 1; i < list_len; i++) list_words[i-1] = list_words[i];
          list_len--;
        end
      end
      default: list_len = 0;
    endcase
    r.count = list_len[4:0];
    return r;
  endfunction

  // one request beat; valid stays high into the next call unless a gap comes first
  task automatic send_list_request(req_t kind, logic [7:0] pos, logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= kind;
    in_position    <= pos;
    in_write_value <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // beat taken at this edge
    pending_list_results.push_back(predict_list_request(kind, pos, word));
  endtask

  // stop sending, let every result drain, then let the read path settle
  task automatic wait_until_list_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_list_results.size() != 0) @(posedge clk);
    repeat (LIST_LATENCY + 2) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle, only with the list idle
  task automatic write_list_capacity(logic [4:0] cap);
    wait_until_list_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_REG_ADDR;
    pwdata  <= {27'd0, cap};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    list_cap_reg = int'(cap);
  endtask

  // every operation at the edges of the list and of the fields
  task automatic test_directed_operations();
    // empty list: reads and removes are out of range
    send_list_request(REQ_GET, 8'd0, 32'h0);
    send_list_request(REQ_DELETE, 8'd0, 32'hFFFF_FFFF);
    // inserts: far past the end, at the front, in the middle, past the end again
    send_list_request(REQ_INSERT, 8'd255, 32'hFFFF_FFFF);
    send_list_request(REQ_INSERT, 8'd0, 32'h0000_0000);
    send_list_request(REQ_INSERT, 8'd1, 32'hA5A5_5A5A);
    send_list_request(REQ_INSERT, 8'd200, 32'h1234_5678);
    // reads at both ends, at the length and at the top position
    send_list_request(REQ_GET, 8'd0, 32'h0);
    send_list_request(REQ_GET, 8'd3, 32'h0);
    send_list_request(REQ_GET, 8'd4, 32'h0);
    send_list_request(REQ_GET, 8'd255, 32'h0);
    // remove from the middle, then out of range
    send_list_request(REQ_DELETE, 8'd1, 32'h0);
    send_list_request(REQ_DELETE, 8'd255, 32'h0);
    // clear empties the list
    send_list_request(REQ_CLEAR, 8'd77, 32'hDEAD_BEEF);
    send_list_request(REQ_GET, 8'd0, 32'h0);
  endtask

  // capacity zero, one, and lowered below the current length
  task automatic test_capacity_limits();
    write_list_capacity(5'd0);
    send_list_request(REQ_INSERT, 8'd0, 32'h1111_1111);
    write_list_capacity(5'd1);
    send_list_request(REQ_INSERT, 8'd0, 32'h2222_2222);
    send_list_request(REQ_INSERT, 8'd0, 32'h3333_3333);
    write_list_capacity(5'd16);
    send_list_request(REQ_INSERT, 8'd0, 32'h4444_4444);
    send_list_request(REQ_INSERT, 8'd9, 32'h5555_5555);
    send_list_request(REQ_INSERT, 8'd1, 32'h6666_6666);
    // four held, capacity two: inserts refused until the length drops below two
    write_list_capacity(5'd2);
    send_list_request(REQ_INSERT, 8'd0, 32'h7777_7777);
    send_list_request(REQ_DELETE, 8'd3, 32'h0);
    send_list_request(REQ_DELETE, 8'd0, 32'h0);
    send_list_request(REQ_DELETE, 8'd1, 32'h0);
    send_list_request(REQ_INSERT, 8'd0, 32'h8888_8888);
  endtask

  // random requests over several capacity settings
  task automatic test_random_traffic();
    int   caps [7];
    int   r;
    req_t kind;
    logic [7:0] pos;
    caps = '{16, 5, 31, 1, 0, 12, 16};
    caps[5] = $urandom_range(2, 15);
    for (int ph = 0; ph < 7; ph++) begin
      write_list_capacity(caps[ph][4:0]);
      for (int n = 0; n < 100; n++) begin
        // back-to-back stretch at the start of every other phase
        steady_traffic = (n < 25) && (ph % 2 == 0);
        // once, hold off until the list has answered everything
        if (ph == 2 && n == 50) wait_until_list_idle();
        r = $urandom_range(0, 99);
        if (r < 45)      kind = REQ_INSERT;
        else if (r < 70) kind = REQ_GET;
        else if (r < 97) kind = REQ_DELETE;
        else             kind = REQ_CLEAR;
        // positions mostly near the live range, some anywhere
        r = $urandom_range(0, 99);
        if (r < 70)      pos = 8'($urandom_range(0, list_len));
        else if (r < 85) pos = 8'($urandom_range(0, 255));
        else             pos = 8'(list_len + $urandom_range(0, 3));
        send_list_request(kind, pos, $urandom);
      end
    end
    steady_traffic = 1'b0;
  endtask

  // receiver side: random stalls on out_ready
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // result checker: each beat against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_list_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d value %h count %0d",
               out_result_status, out_read_value, out_element_count);
        fail_count++;
      end else begin
        want = pending_list_results.pop_front();
        if (out_result_status !== want.status) begin
          $error("result_status expected %0d actual %0d", want.status, out_result_status);
          fail_count++;
        end
        if (out_read_value !== want.value) begin
          $error("read_value expected %h actual %h", want.value, out_read_value);
          fail_count++;
        end
        if (out_element_count !== want.count) begin
          $error("element_count expected %0d actual %0d", want.count, out_element_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    fail_count     = 0;
    cycle_count    = 0;
    steady_traffic = 1'b0;
    list_len       = 0;
    list_cap_reg   = 16;
    // every input known from time zero
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req_type    <= REQ_INSERT;
    in_position    <= '0;
    in_write_value <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_operations();
    test_capacity_limits();
    test_random_traffic();

    // drain everything still in flight
    wait_until_list_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
